>>> sv/wavp_pkg.sv
// wavp_pkg: shared types, codes and constants for the RIFF/WAVE header parser.
// No dependencies; used by every module of the parser and by its checker.
`default_nettype none
package wavp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } req_in_t;

  typedef struct packed {
    logic        audio_valid;
    logic [7:0]  audio_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } req_out_t;

  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_SHORT_FMT = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;
  localparam logic [2:0] ST_TAG       = 3'd5;
  localparam logic [2:0] ST_MISSING   = 3'd6;

  // byte 0 of each word sits in bits [7:0]
  localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
  localparam logic [31:0] WAVE_WORD = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA  = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_FLOAT      = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  localparam int FMT_KEEP = 16;
  localparam int RIFF_HDR = 12;
  localparam int CHDR_LEN = 8;

  localparam int BUF_DEPTH = 2;

  function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      2'd2:    b = word[23:16];
      default: b = word[31:24];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> sv/wavp_core.sv
// wavp_core: parser state and per-byte result logic for the RIFF/WAVE parser.
// Depends on wavp_pkg.
`default_nettype none
module wavp_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire wavp_pkg::req_in_t req,
  output wavp_pkg::req_out_t     res
);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_CHDR,
    PH_BODY,
    PH_PAD,
    PH_STOP
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       header_count;
    logic [31:0]      chunk_tag;
    logic [31:0]      chunk_length;
    logic [31:0]      bytes_left;
    logic             pad_pending;
    logic [15:0][7:0] fmt_capture;
    logic [15:0][7:0] fmt_accepted;
    logic             have_fmt;
    logic             have_data;
    logic [31:0]      accepted_data_length;
    logic [2:0]       error_code;
  } core_st_t;

  core_st_t st;
  core_st_t st_next;
  wavp_pkg::req_out_t res_next;

  always_comb begin
    logic [7:0]  b;
    logic        done;
    logic        bad;
    logic [31:0] idx;
    logic [15:0] tag16;
    logic [2:0]  status;
    b        = req.file_byte;
    done     = 1'b0;
    bad      = 1'b0;
    idx      = st.chunk_length - st.bytes_left;
    tag16    = '0;
    status   = wavp_pkg::ST_PENDING;
    st_next  = st;
    res_next = '0;

    case (st.phase)
      PH_RIFF: begin
        if (st.header_count < 4'd4) begin
          bad = (b != wavp_pkg::word_byte(wavp_pkg::RIFF_WORD, st.header_count[1:0]));
        end else if (st.header_count >= 4'd8) begin
          bad = (b != wavp_pkg::word_byte(wavp_pkg::WAVE_WORD, st.header_count[1:0]));
        end
        if (bad) begin
          st_next.error_code = wavp_pkg::ST_MAGIC;
          st_next.phase      = PH_STOP;
        end else if (st.header_count == 4'(wavp_pkg::RIFF_HDR - 1)) begin
          st_next.header_count = '0;
          st_next.phase        = PH_CHDR;
        end else begin
          st_next.header_count = st.header_count + 4'd1;
        end
      end
      PH_CHDR: begin
        if (st.header_count < 4'd4) begin
          st_next.chunk_tag = {b, st.chunk_tag[31:8]};
        end else begin
          st_next.chunk_length = {b, st.chunk_length[31:8]};
        end
        st_next.header_count = st.header_count + 4'd1;
        if (st.header_count == 4'(wavp_pkg::CHDR_LEN - 1)) begin
          st_next.header_count = '0;
          st_next.bytes_left   = st_next.chunk_length;
          if (st_next.chunk_length == '0) begin
            done = 1'b1;
          end else begin
            st_next.phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (st.chunk_tag == wavp_pkg::TAG_DATA) begin
          res_next.audio_valid = 1'b1;
          res_next.audio_byte  = b;
        end else if (st.chunk_tag == wavp_pkg::TAG_FMT && idx[31:4] == '0) begin
          st_next.fmt_capture[idx[3:0]] = b;
        end
        st_next.bytes_left = st.bytes_left - 32'd1;
        done = (st.bytes_left == 32'd1);
      end
      PH_PAD: begin
        st_next.pad_pending = 1'b0;
        st_next.phase       = PH_CHDR;
      end
      default: begin
      end
    endcase

    if (done) begin
      bad   = 1'b0;
      tag16 = {st_next.fmt_capture[1], st_next.fmt_capture[0]};
      if (st_next.chunk_tag == wavp_pkg::TAG_FMT) begin
        bad = 1'b1;
        if (st_next.chunk_length < 32'(wavp_pkg::FMT_KEEP)) begin
          st_next.error_code = wavp_pkg::ST_SHORT_FMT;
        end else if ({st_next.fmt_capture[13], st_next.fmt_capture[12]} == '0 ||
                     st_next.fmt_capture[11:8] == '0) begin
          st_next.error_code = wavp_pkg::ST_ZERO;
        end else if (tag16 != wavp_pkg::FMT_PCM && tag16 != wavp_pkg::FMT_FLOAT &&
                     tag16 != wavp_pkg::FMT_EXTENSIBLE) begin
          st_next.error_code = wavp_pkg::ST_TAG;
        end else begin
          bad                  = 1'b0;
          st_next.fmt_accepted = st_next.fmt_capture;
          st_next.have_fmt     = 1'b1;
        end
      end else if (st_next.chunk_tag == wavp_pkg::TAG_DATA) begin
        st_next.accepted_data_length = st_next.chunk_length;
        st_next.have_data            = 1'b1;
      end
      if (bad) begin
        st_next.phase = PH_STOP;
      end else begin
        st_next.pad_pending = st_next.chunk_length[0];
        st_next.phase       = st_next.chunk_length[0] ? PH_PAD : PH_CHDR;
      end
    end

    if (req.last_byte) begin
      if (st_next.error_code != wavp_pkg::ST_PENDING) begin
        status = st_next.error_code;
      end else if (st_next.phase == PH_RIFF) begin
        status = wavp_pkg::ST_MAGIC;
      end else if (!st_next.have_fmt || !st_next.have_data) begin
        status = wavp_pkg::ST_MISSING;
      end else begin
        status = wavp_pkg::ST_OK;
      end
      res_next.done_res = 1'b1;
      res_next.status   = status;
      if (status == wavp_pkg::ST_OK) begin
        res_next.format_tag    = {st_next.fmt_accepted[1], st_next.fmt_accepted[0]};
        res_next.channel_count = {st_next.fmt_accepted[3], st_next.fmt_accepted[2]};
        res_next.sample_rate   = st_next.fmt_accepted[7:4];
        res_next.byte_rate     = st_next.fmt_accepted[11:8];
        res_next.frame_align   = {st_next.fmt_accepted[13], st_next.fmt_accepted[12]};
        res_next.sample_bits   = {st_next.fmt_accepted[15], st_next.fmt_accepted[14]};
        res_next.data_length   = st_next.accepted_data_length;
      end
    end
  end

  assign res = res_next;

  // restart on the last byte of each file
  always_ff @(posedge clk) begin
    if (rst || (take && req.last_byte)) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/wavp_obuf.sv
// wavp_obuf: two-entry result buffer that decouples the parser from its consumer.
// Depends on wavp_pkg.
`default_nettype none
module wavp_obuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire wavp_pkg::req_out_t push_req,
  output logic                    can_push,
  output logic                    dst_valid,
  input  wire logic               dst_ready,
  output wavp_pkg::req_out_t      dst_req
);

  localparam int CW = $clog2(wavp_pkg::BUF_DEPTH + 1);

  wavp_pkg::req_out_t slot0;
  wavp_pkg::req_out_t slot1;
  logic [CW-1:0]      count;
  logic               pop;

  assign pop       = dst_valid && dst_ready;
  assign can_push  = (count != CW'(wavp_pkg::BUF_DEPTH));
  assign dst_valid = (count != '0);
  assign dst_req   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(push) - CW'(pop);
    end
    if (pop) begin
      slot0 <= slot1;
      if (push && count == CW'(1)) begin
        slot0 <= push_req;
      end
      if (push && count == CW'(2)) begin
        slot1 <= push_req;
      end
    end else if (push) begin
      if (count == '0) begin
        slot0 <= push_req;
      end else begin
        slot1 <= push_req;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/riff_wave_header_parser.sv
// riff_wave_header_parser: top level of the RIFF/WAVE header parser.
// Depends on wavp_pkg, wavp_core and wavp_obuf.
//
//   channel  handshake              payload     moves
//   src      src_valid/src_ready    src_req     one file byte per request
//   dst      dst_valid/dst_ready    dst_req     one result per file byte
//
// One request per cycle while src_ready is high; each result is registered in the buffer.
// The parser state updates once per byte; a two-entry buffer
// holds results so src stays ready while one result waits on dst.
// src_ready drops only when both buffer entries are full.
// rst is synchronous and clears parser state and the buffer.
`default_nettype none
module riff_wave_header_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  output logic                    src_ready,
  input  wire wavp_pkg::req_in_t  src_req,
  output logic                    dst_valid,
  input  wire logic               dst_ready,
  output wavp_pkg::req_out_t      dst_req
);

  logic               take;
  wavp_pkg::req_out_t res;

  assign take = src_valid && src_ready;

  wavp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (src_req),
    .res  (res)
  );

  wavp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_req  (res),
    .can_push  (src_ready),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_req   (dst_req)
  );

endmodule
`default_nettype wire

>>> sv/wavp_check.sv
// wavp_check: port-level assertions for riff_wave_header_parser, bound to the top.
// Depends on wavp_pkg.
`default_nettype none
module wavp_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               src_ready,
  input wire logic               dst_valid,
  input wire logic               dst_ready,
  input wire wavp_pkg::req_out_t dst_req
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_req))
    else $error("result changed while stalled");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> dst_valid)
    else $error("input stalled with no result pending");

  a_not_done: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_req.done_res |->
      dst_req.status == wavp_pkg::ST_PENDING && dst_req.data_length == '0)
    else $error("status shown before last byte");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_req.done_res && dst_req.status != wavp_pkg::ST_OK |->
      dst_req.format_tag == '0 && dst_req.sample_rate == '0 && dst_req.data_length == '0)
    else $error("format fields set on failed file");

  a_audio_byte: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_req.audio_valid |-> dst_req.audio_byte == '0)
    else $error("audio byte outside data chunk");

endmodule

bind riff_wave_header_parser wavp_check u_wavp_check (
  .clk       (clk),
  .rst       (rst),
  .src_ready (src_ready),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .dst_req   (dst_req)
);
`default_nettype wire

>>> verif/tb_riff_wave_header_parser.sv
// Self-checking bench for riff_wave_header_parser: feeds WAV files one byte per request
// and checks every result against a built-in byte-level parser model.
// Depends on wavp_pkg and the riff_wave_header_parser RTL.
module tb_riff_wave_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {PH_RIFF, PH_CHDR, PH_BODY, PH_PAD, PH_STOP} parse_phase_t;
  typedef enum logic [1:0] {RCV_FREE, RCV_RANDOM, RCV_PERIODIC, RCV_SPARSE} rcv_mode_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_ready;
  wavp_pkg::req_in_t  src_req = '0;
  logic               dst_valid;
  logic               dst_ready = 1'b0;
  wavp_pkg::req_out_t dst_req;

  // parser model state
  parse_phase_t ph;
  int unsigned  hdr_cnt;
  logic [31:0]  cur_tag;
  logic [31:0]  cur_len;
  logic [32:0]  remain;
  logic [127:0] fmt_cap;
  logic [127:0] fmt_keep;
  logic         got_fmt;
  logic         got_data;
  logic [31:0]  kept_data_len;
  logic [2:0]   err_code;

  wavp_pkg::req_out_t result_q[$];
  wavp_pkg::req_out_t want;
  logic [7:0]  file_q[$];
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned files_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned audio_seen = 0;
  int unsigned status_seen[8];
  rcv_mode_t   rcv_mode = RCV_FREE;
  int unsigned rcv_left = 0;
  logic [1:0]  rcv_tick = '0;

  riff_wave_header_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_req   (src_req),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_req   (dst_req)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  function automatic void clear_parser();
    ph = PH_RIFF;
    hdr_cnt = 0;
    cur_tag = '0;
    cur_len = '0;
    remain = '0;
    fmt_cap = '0;
    fmt_keep = '0;
    got_fmt = 1'b0;
    got_data = 1'b0;
    kept_data_len = '0;
    err_code = wavp_pkg::ST_PENDING;
  endfunction

  function automatic void abort_file(input logic [2:0] code);
    err_code = code;
    ph = PH_STOP;
  endfunction

  function automatic void close_chunk();
    logic [15:0] tg;
    tg = fmt_cap[15:0];
    if (cur_tag == wavp_pkg::TAG_FMT) begin
      if (cur_len < wavp_pkg::FMT_KEEP) begin
        abort_file(wavp_pkg::ST_SHORT_FMT);
        return;
      end
      if (fmt_cap[8*12 +: 16] == '0 || fmt_cap[8*8 +: 32] == '0) begin
        abort_file(wavp_pkg::ST_ZERO);
        return;
      end
      if (tg != wavp_pkg::FMT_PCM && tg != wavp_pkg::FMT_FLOAT &&
          tg != wavp_pkg::FMT_EXTENSIBLE) begin
        abort_file(wavp_pkg::ST_TAG);
        return;
      end
      fmt_keep = fmt_cap;
      got_fmt = 1'b1;
    end else if (cur_tag == wavp_pkg::TAG_DATA) begin
      kept_data_len = cur_len;
      got_data = 1'b1;
    end
    ph = cur_len[0] ? PH_PAD : PH_CHDR;
  endfunction

  function automatic wavp_pkg::req_out_t parse_byte(input logic [7:0] b, input logic l);
    wavp_pkg::req_out_t r;
    logic [32:0] idx;
    logic [31:0] riff_w;
    logic [31:0] wave_w;
    logic [2:0]  st;
    r = '0;
    riff_w = wavp_pkg::RIFF_WORD;
    wave_w = wavp_pkg::WAVE_WORD;
    case (ph)
      PH_RIFF: begin
        if (hdr_cnt < 4 && b != riff_w[8*hdr_cnt +: 8]) begin
          abort_file(wavp_pkg::ST_MAGIC);
        end else if (hdr_cnt >= 8 && b != wave_w[8*(hdr_cnt-8) +: 8]) begin
          abort_file(wavp_pkg::ST_MAGIC);
        end else begin
          hdr_cnt++;
          if (hdr_cnt >= wavp_pkg::RIFF_HDR) begin
            hdr_cnt = 0;
            ph = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        if (hdr_cnt < 4) cur_tag = {b, cur_tag[31:8]};
        else cur_len = {b, cur_len[31:8]};
        hdr_cnt++;
        if (hdr_cnt >= wavp_pkg::CHDR_LEN) begin
          hdr_cnt = 0;
          remain = {1'b0, cur_len};
          if (cur_len == '0) close_chunk();
          else ph = PH_BODY;
        end
      end
      PH_BODY: begin
        idx = {1'b0, cur_len} - remain;
        if (cur_tag == wavp_pkg::TAG_DATA) begin
          r.audio_valid = 1'b1;
          r.audio_byte = b;
        end else if (cur_tag == wavp_pkg::TAG_FMT && idx < wavp_pkg::FMT_KEEP) begin
          fmt_cap[8*idx[3:0] +: 8] = b;
        end
        remain--;
        if (remain == '0) close_chunk();
      end
      PH_PAD: ph = PH_CHDR;
      default: ;
    endcase
    if (l) begin
      if (err_code != wavp_pkg::ST_PENDING) st = err_code;
      else if (ph == PH_RIFF) st = wavp_pkg::ST_MAGIC;
      else if (!got_fmt || !got_data) st = wavp_pkg::ST_MISSING;
      else st = wavp_pkg::ST_OK;
      r.done_res = 1'b1;
      r.status = st;
      if (st == wavp_pkg::ST_OK) begin
        r.format_tag = fmt_keep[15:0];
        r.channel_count = fmt_keep[31:16];
        r.sample_rate = fmt_keep[63:32];
        r.byte_rate = fmt_keep[95:64];
        r.frame_align = fmt_keep[111:96];
        r.sample_bits = fmt_keep[127:112];
        r.data_length = kept_data_len;
      end
      clear_parser();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // send one byte; valid stays high across a burst and drops for a gap
  task automatic send_byte(input logic [7:0] b, input logic l);
    wavp_pkg::req_in_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    r.file_byte = b;
    r.last_byte = l;
    src_req <= r;
    src_valid <= 1'b1;
    do @(posedge clk); while (!src_ready);
    result_q.push_back(parse_byte(b, l));
    bytes_sent++;
  endtask

  task automatic send_file();
    int unsigned n;
    n = file_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    file_q.delete();
    files_sent++;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_header();
    put_word(wavp_pkg::RIFF_WORD);
    put_word($urandom);
    put_word(wavp_pkg::WAVE_WORD);
  endtask

  // chunk with random payload and a pad byte when the length is odd
  task automatic put_chunk(input logic [31:0] tag, input int unsigned len);
    put_word(tag);
    put_word(len);
    for (int unsigned i = 0; i < len + len % 2; i++) file_q.push_back(8'($urandom));
  endtask

  task automatic put_fmt(input logic [15:0] tag, ch, input logic [31:0] rate, brate,
                         input logic [15:0] align, sbits, input int unsigned len);
    logic [127:0] body;
    body = {sbits, align, brate, rate, ch, tag};
    put_word(wavp_pkg::TAG_FMT);
    put_word(len);
    for (int unsigned i = 0; i < len + len % 2; i++) begin
      if (i < wavp_pkg::FMT_KEEP && i < len) file_q.push_back(body[8*i +: 8]);
      else file_q.push_back(8'($urandom));
    end
  endtask

  task automatic put_random_fmt();
    logic [15:0] tg;
    int unsigned len;
    int unsigned pick;
    case ($urandom_range(0, 3))
      0: tg = wavp_pkg::FMT_PCM;
      1: tg = wavp_pkg::FMT_FLOAT;
      2: tg = wavp_pkg::FMT_EXTENSIBLE;
      default: tg = 16'($urandom);
    endcase
    pick = $urandom_range(0, 7);
    if (pick == 0) len = $urandom_range(0, 15);
    else if (pick == 1) len = $urandom_range(17, 22);
    else len = wavp_pkg::FMT_KEEP;
    put_fmt(tg, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
            $urandom, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom,
            ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom), 16'($urandom), len);
  endtask

  task automatic test_good_file();
    put_header();
    put_fmt(wavp_pkg::FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16, 16);
    put_chunk(wavp_pkg::TAG_DATA, 3);
    send_file();
  endtask

  task automatic test_field_extremes();
    put_header();
    put_fmt(wavp_pkg::FMT_EXTENSIBLE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
            16'hFFFF, 17);
    put_chunk(wavp_pkg::TAG_DATA, 0);
    send_file();
    put_header();
    put_chunk(32'h5453_494C, 1);
    put_fmt(wavp_pkg::FMT_FLOAT, 16'd0, 32'd0, 32'd1, 16'd1, 16'd0, 16);
    put_chunk(wavp_pkg::TAG_DATA, 1);
    put_word(wavp_pkg::TAG_DATA);
    put_word(32'd2);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    send_file();
  endtask

  task automatic test_header_errors();
    file_q.push_back(wavp_pkg::RIFF_WORD[7:0]);
    file_q.push_back(8'h58);
    send_file();
    put_word(wavp_pkg::RIFF_WORD);
    put_word($urandom);
    put_word(wavp_pkg::WAVE_WORD ^ 32'h8000_0000);
    put_chunk(wavp_pkg::TAG_DATA, 2);
    send_file();
    put_word(wavp_pkg::RIFF_WORD);
    repeat (3) file_q.push_back(8'($urandom));
    send_file();
    file_q.push_back(wavp_pkg::RIFF_WORD[7:0]);
    send_file();
    put_header();
    send_file();
  endtask

  task automatic test_fmt_errors();
    for (int v = 0; v < 4; v++) begin
      put_header();
      case (v)
        0: put_fmt(wavp_pkg::FMT_PCM, 16'd1, 32'd8000, 32'd16000, 16'd2, 16'd16, 15);
        1: put_fmt(wavp_pkg::FMT_PCM, 16'd1, 32'd8000, 32'd16000, 16'd0, 16'd16, 16);
        2: put_fmt(wavp_pkg::FMT_FLOAT, 16'd1, 32'd8000, 32'd0, 16'd4, 16'd32, 16);
        default: put_fmt(16'h0002, 16'd1, 32'd8000, 32'd4000, 16'd1, 16'd4, 16);
      endcase
      put_chunk(wavp_pkg::TAG_DATA, 2);
      send_file();
    end
  endtask

  task automatic test_missing_and_truncated();
    put_header();
    put_fmt(wavp_pkg::FMT_PCM, 16'd1, 32'd22050, 32'd22050, 16'd1, 16'd8, 16);
    send_file();
    put_header();
    put_chunk(wavp_pkg::TAG_DATA, 4);
    send_file();
    put_header();
    put_fmt(wavp_pkg::FMT_PCM, 16'd1, 32'd22050, 32'd44100, 16'd2, 16'd16, 16);
    put_chunk(wavp_pkg::TAG_DATA, 2);
    put_word(wavp_pkg::TAG_DATA);
    put_word(32'hFFFF_FFFF);
    repeat (5) file_q.push_back(8'($urandom));
    send_file();
    put_header();
    put_fmt(wavp_pkg::FMT_PCM, 16'd1, 32'd11025, 32'd11025, 16'd1, 16'd8, 16);
    put_fmt(wavp_pkg::FMT_EXTENSIBLE, 16'd6, 32'd48000, 32'd864000, 16'd18, 16'd24, 18);
    put_chunk(wavp_pkg::TAG_DATA, 1);
    repeat (3) file_q.push_back(8'($urandom));
    send_file();
    put_header();
    put_fmt(wavp_pkg::FMT_FLOAT, 16'd2, 32'd96000, 32'd768000, 16'd8, 16'd32, 16);
    put_chunk(wavp_pkg::TAG_DATA, 4);
    put_word(wavp_pkg::TAG_FMT);
    put_word(32'd16);
    repeat (6) file_q.push_back(8'h00);
    send_file();
  endtask

  task automatic test_random_files();
    int unsigned start;
    int unsigned kind;
    int unsigned pos;
    int unsigned cut;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        if ($urandom_range(0, 1)) file_q.push_back(wavp_pkg::RIFF_WORD[7:0]);
        repeat ($urandom_range(1, 14)) file_q.push_back(8'($urandom));
      end else if (kind == 1) begin
        put_header();
        pos = $urandom_range(0, 7);
        if (pos >= 4) pos += 4;
        file_q[pos] = file_q[pos] ^ 8'(1 << $urandom_range(0, 7));
        repeat ($urandom_range(0, 10)) file_q.push_back(8'($urandom));
      end else begin
        put_header();
        if ($urandom_range(0, 4) != 0) put_random_fmt();
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 4))
            0, 1: put_random_fmt();
            2, 3: put_chunk(wavp_pkg::TAG_DATA, $urandom_range(0, 12));
            default: put_chunk($urandom, $urandom_range(0, 6));
          endcase
        end
        if ($urandom_range(0, 4) != 0) put_chunk(wavp_pkg::TAG_DATA, $urandom_range(0, 12));
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, file_q.size());
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
      end
      send_file();
    end
  endtask

  // receiver: switch between free-running, random, periodic and sparse acceptance
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode <= rcv_mode_t'($urandom_range(0, 3));
      rcv_left <= $urandom_range(16, 128);
    end else begin
      rcv_left <= rcv_left - 1;
    end
    case (rcv_mode)
      RCV_FREE:     dst_ready <= 1'b1;
      RCV_RANDOM:   dst_ready <= 1'($urandom_range(0, 1));
      RCV_PERIODIC: dst_ready <= (rcv_tick != 2'd0);
      default:      dst_ready <= ($urandom_range(0, 7) == 0);
    endcase
    rcv_tick <= rcv_tick + 2'd1;
  end

  always @(posedge clk) begin
    if (!rst && dst_valid && dst_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, dst_req);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        check_field("audio_valid", 32'(want.audio_valid), 32'(dst_req.audio_valid));
        check_field("audio_byte", 32'(want.audio_byte), 32'(dst_req.audio_byte));
        check_field("done_res", 32'(want.done_res), 32'(dst_req.done_res));
        check_field("status", 32'(want.status), 32'(dst_req.status));
        check_field("format_tag", 32'(want.format_tag), 32'(dst_req.format_tag));
        check_field("channel_count", 32'(want.channel_count), 32'(dst_req.channel_count));
        check_field("sample_rate", want.sample_rate, dst_req.sample_rate);
        check_field("byte_rate", want.byte_rate, dst_req.byte_rate);
        check_field("frame_align", 32'(want.frame_align), 32'(dst_req.frame_align));
        check_field("sample_bits", 32'(want.sample_bits), 32'(dst_req.sample_bits));
        check_field("data_length", want.data_length, dst_req.data_length);
        results_checked++;
        if (dst_req.audio_valid) audio_seen++;
        if (dst_req.done_res) status_seen[dst_req.status]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               result_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_good_file();
    test_field_extremes();
    test_header_errors();
    test_fmt_errors();
    test_missing_and_truncated();
    test_random_files();
    @(negedge clk);
    src_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d files, %0d bytes, %0d results checked, %0d audio bytes passed",
             files_sent, bytes_sent, results_checked, audio_seen);
    $display("Final status: ok %0d, magic %0d, short fmt %0d, zero %0d, tag %0d, missing %0d",
             status_seen[wavp_pkg::ST_OK], status_seen[wavp_pkg::ST_MAGIC],
             status_seen[wavp_pkg::ST_SHORT_FMT], status_seen[wavp_pkg::ST_ZERO],
             status_seen[wavp_pkg::ST_TAG], status_seen[wavp_pkg::ST_MISSING]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
